// ----- hw/rtl/brm_pkg.sv -----
// Shared widths, register codes and the configuration struct of the radial mask block.
package brm_pkg;

    localparam int GRID_W  = 13;
    localparam int PITCH_W = 20;
    localparam int RAD_W   = 24;
    localparam int ORDER_W = 5;
    localparam int IDX_W   = 12;
    localparam int HALF_W  = 12;
    localparam int MASK_W  = 17;
    localparam int DIFF_W  = 13;
    localparam int OFF_W   = DIFF_W + PITCH_W - 5;
    localparam int SUM_W   = 2 * OFF_W + 1;
    localparam int ROOT_W  = (SUM_W + 1) / 2;
    localparam int QUO1_W  = ROOT_W + 16;
    localparam int Q_W     = 32;
    localparam int P_W     = 32;
    localparam int DEN2_W  = P_W + 1;
    localparam int POW_STAGES = (1 << ORDER_W) - 1;

    localparam logic [P_W-1:0]    P_ONE      = P_W'(65536);
    localparam logic [Q_W-1:0]    SAT32      = '1;
    localparam logic [DEN2_W-1:0] TWO_POW_32 = {1'b1, 32'b0};

    typedef enum logic [1:0] {
        REG_GRID_SIZE    = 2'd0,
        REG_PIXEL_PITCH  = 2'd1,
        REG_RADIUS       = 2'd2,
        REG_FILTER_ORDER = 2'd3
    } brm_reg_t;

    typedef struct packed {
        logic [HALF_W-1:0]  half;
        logic [PITCH_W-1:0] pitch;
        logic [RAD_W-1:0]   radius;
        logic [ORDER_W-1:0] order;
    } brm_cfg_t;

endpackage

// ----- hw/rtl/brm_offset.sv -----
// Front end: axis offsets, their squares and the squared distance, three stages.
module brm_offset
    import brm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  brm_cfg_t           cfg,
    input  logic               in_vld,
    input  logic [IDX_W-1:0]   row,
    input  logic [IDX_W-1:0]   col,
    output logic               out_vld,
    output logic [SUM_W-1:0]   sum
);

    logic [2:0]             vld_reg;
    logic [OFF_W-1:0]       x_reg, y_reg;
    logic [2*OFF_W-1:0]     xx_reg, yy_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [OFF_W-1:0]       x_next, y_next;

    function automatic logic [OFF_W-1:0] offset(input logic [IDX_W-1:0] idx,
                                                input logic [HALF_W-1:0] half,
                                                input logic [PITCH_W-1:0] pitch);
        logic [DIFF_W-1:0] a, b, d;
        logic [DIFF_W+PITCH_W-1:0] m;
        a = {idx, 1'b1};
        b = {half, 1'b0};
        d = (a >= b) ? (a - b) : (b - a);
        m = (DIFF_W+PITCH_W)'(d) * (DIFF_W+PITCH_W)'(pitch);
        // Q.21 to Q.16; the slice keeps every upper bit of the product, so no cap is needed.
        return m[DIFF_W+PITCH_W-1:5];
    endfunction

    assign x_next = offset(row, cfg.half, cfg.pitch);
    assign y_next = offset(col, cfg.half, cfg.pitch);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            xx_reg  <= (2*OFF_W)'(x_reg) * (2*OFF_W)'(x_reg);
            yy_reg  <= (2*OFF_W)'(y_reg) * (2*OFF_W)'(y_reg);
            sum_reg <= SUM_W'(xx_reg) + SUM_W'(yy_reg);
        end
    end

    assign out_vld = vld_reg[2];
    assign sum     = sum_reg;

endmodule

// ----- hw/rtl/brm_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module brm_sqrt
    import brm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [SUM_W-1:0]  radicand,
    output logic              out_vld,
    output logic [ROOT_W-1:0] root
);

    localparam int SW = 2 * ROOT_W;
    localparam int RW = ROOT_W + 2;

    logic              vld_reg  [ROOT_W];
    logic [SW-1:0]     rad_reg  [ROOT_W];
    logic [RW-1:0]     rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic              vld_in;
            logic [SW-1:0]     rad_in;
            logic [RW-1:0]     rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [RW+1:0]     cur, trial;
            logic              take;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign rad_in  = SW'(radicand);
                assign rem_in  = '0;
                assign root_in = '0;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[k-1];
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            assign cur   = {rem_in, rad_in[SW-1:SW-2]};
            assign trial = {2'b00, root_in, 2'b01};
            assign take  = (cur >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= {rad_in[SW-3:0], 2'b00};
                    rem_reg[k]  <= take ? RW'(cur - trial) : RW'(cur);
                    root_reg[k] <= {root_in[ROOT_W-2:0], take};
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[ROOT_W-1];
    assign root    = root_reg[ROOT_W-1];

endmodule

// ----- hw/rtl/brm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module brm_div #(
    parameter int NW = 45,
    parameter int DW = 24,
    parameter int QW = 45
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          out_vld,
    output logic [QW-1:0] quo
);

    logic          vld_reg [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [QW-1:0] quo_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            logic          vld_in;
            logic [DW-1:0] rem_in, den_in;
            logic [QW-1:0] lo_in, quo_in;
            logic [DW:0]   cur;
            logic          take;

            if (k == 0)
            begin : g_first
                // Numerator bits above the quotient width are below the divisor.
                assign vld_in = in_vld;
                assign rem_in = DW'(num >> QW);
                assign den_in = den;
                assign lo_in  = num[QW-1:0];
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign vld_in = vld_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign lo_in  = lo_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            assign cur  = {rem_in, lo_in[QW-1]};
            assign take = (cur >= {1'b0, den_in});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? DW'(cur - {1'b0, den_in}) : DW'(cur);
                    den_reg[k] <= den_in;
                    lo_reg[k]  <= lo_in << 1;
                    quo_reg[k] <= {quo_in[QW-2:0], take};
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[QW-1];
    assign quo     = quo_reg[QW-1];

endmodule

// ----- hw/rtl/brm_power.sv -----
// Power chain: one saturating Q.16 multiply per stage, applied while the stage is below the order.
module brm_power
    import brm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [ORDER_W-1:0] order,
    input  logic               in_vld,
    input  logic [Q_W-1:0]     q,
    output logic               out_vld,
    output logic [P_W-1:0]     p
);

    logic           vld_reg [POW_STAGES];
    logic [P_W-1:0] p_reg   [POW_STAGES];
    logic [Q_W-1:0] q_reg   [POW_STAGES];

    genvar k;
    generate
        for (k = 0; k < POW_STAGES; k++)
        begin : g_stage
            logic               vld_in;
            logic [P_W-1:0]     p_in;
            logic [Q_W-1:0]     q_in;
            logic [P_W+Q_W-1:0] prod;
            logic [P_W-1:0]     p_mul;

            if (k == 0)
            begin : g_first
                assign vld_in = in_vld;
                assign p_in   = P_ONE;
                assign q_in   = q;
            end
            else
            begin : g_next
                assign vld_in = vld_reg[k-1];
                assign p_in   = p_reg[k-1];
                assign q_in   = q_reg[k-1];
            end

            assign prod  = (P_W+Q_W)'(p_in) * (P_W+Q_W)'(q_in);
            assign p_mul = (|prod[P_W+Q_W-1:P_W+16]) ? SAT32 : prod[P_W+15:16];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p_reg[k] <= (ORDER_W'(k) < order) ? p_mul : p_in;
                    q_reg[k] <= q_in;
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[POW_STAGES-1];
    assign p       = p_reg[POW_STAGES-1];

endmodule

// ----- hw/rtl/butterworth_radial_mask_top.sv -----
// Top level of the Butterworth radial mask generator with its register port.
//
// A request carries a row and a column index; the block answers each request
// with one mask gain 1/(1+(r/R)^N) in unsigned Q1.16 on the mask channel.
// Requests and results use valid/stall handshakes; a request is taken at a
// clock edge where req_valid is high and req_stall is low.
// Every stage is a register stage, so while the receiver does not stall, a
// new request enters every cycle and results leave at one per cycle in
// request order. The pipeline has three front stages (offsets, squares,
// sum), 29 square-root stages, 45 stages for r/R, 31 power stages (one per
// possible order step) and 17 stages for the final reciprocal.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall rises; nothing is dropped or repeated.
// Reset empties the pipeline and loads the default grid size, pitch, radius
// and order. Registers are written through the APB-style port and should be
// changed only while no request is in flight.
module butterworth_radial_mask_top
    import brm_pkg::*;
#(
    parameter int MAX_GRID = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [IDX_W-1:0]  row_index,
    input  logic [IDX_W-1:0]  col_index,
    output logic              mask_valid,
    input  logic              mask_stall,
    output logic [MASK_W-1:0] mask_value
);

    localparam logic [16:0] MAX_GRID_C = 17'(MAX_GRID);

    logic [GRID_W-1:0]  grid_size_reg;
    logic [PITCH_W-1:0] pixel_pitch_reg;
    logic [RAD_W-1:0]   radius_reg;
    logic [ORDER_W-1:0] filter_order_reg;

    brm_reg_t          reg_sel;
    brm_cfg_t          cfg;
    logic [16:0]       grid_clamped;
    logic              en;

    logic              sum_vld, root_vld, quo_vld, pow_vld, mask_vld;
    logic [SUM_W-1:0]  sum;
    logic [ROOT_W-1:0] root;
    logic [QUO1_W-1:0] quo1;
    logic [Q_W-1:0]    q_sat;
    logic [P_W-1:0]    p;
    logic [MASK_W-1:0] quo2;

    assign reg_sel = brm_reg_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg    <= GRID_W'(1024);
            pixel_pitch_reg  <= PITCH_W'(36012);
            radius_reg       <= RAD_W'(65536);
            filter_order_reg <= ORDER_W'(2);
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_sel)
                REG_GRID_SIZE:    grid_size_reg    <= pwdata[GRID_W-1:0];
                REG_PIXEL_PITCH:  pixel_pitch_reg  <= pwdata[PITCH_W-1:0];
                REG_RADIUS:       radius_reg       <= pwdata[RAD_W-1:0];
                REG_FILTER_ORDER: filter_order_reg <= pwdata[ORDER_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_GRID_SIZE:    prdata = 32'(grid_size_reg);
            REG_PIXEL_PITCH:  prdata = 32'(pixel_pitch_reg);
            REG_RADIUS:       prdata = 32'(radius_reg);
            REG_FILTER_ORDER: prdata = 32'(filter_order_reg);
            default:          prdata = '0;
        endcase
    end

    // A zero radius behaves as the smallest step.
    assign grid_clamped = (17'(grid_size_reg) > MAX_GRID_C) ? MAX_GRID_C
                                                             : 17'(grid_size_reg);
    assign cfg.half   = grid_clamped[HALF_W:1];
    assign cfg.pitch  = pixel_pitch_reg;
    assign cfg.radius = (radius_reg == '0) ? RAD_W'(1) : radius_reg;
    assign cfg.order  = filter_order_reg;

    // The pipeline advances unless a finished result is held by the receiver.
    assign en        = !(mask_valid && mask_stall);
    assign req_stall = !en;

    brm_offset u_offset (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg),
        .in_vld  (req_valid),
        .row     (row_index),
        .col     (col_index),
        .out_vld (sum_vld),
        .sum     (sum)
    );

    brm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sum_vld),
        .radicand (sum),
        .out_vld  (root_vld),
        .root     (root)
    );

    brm_div #(
        .NW (QUO1_W),
        .DW (RAD_W),
        .QW (QUO1_W)
    ) u_ratio (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (root_vld),
        .num     ({root, 16'b0}),
        .den     (cfg.radius),
        .out_vld (quo_vld),
        .quo     (quo1)
    );

    assign q_sat = (|quo1[QUO1_W-1:Q_W]) ? SAT32 : quo1[Q_W-1:0];

    brm_power u_power (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .order   (cfg.order),
        .in_vld  (quo_vld),
        .q       (q_sat),
        .out_vld (pow_vld),
        .p       (p)
    );

    brm_div #(
        .NW (DEN2_W),
        .DW (DEN2_W),
        .QW (MASK_W)
    ) u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (pow_vld),
        .num     (TWO_POW_32),
        .den     (DEN2_W'(p) + DEN2_W'(P_ONE)),
        .out_vld (mask_vld),
        .quo     (quo2)
    );

    assign mask_valid = mask_vld;
    assign mask_value = quo2;

endmodule

// ----- hw/rtl/brm_checker.sv -----
// Port-level checks of the radial mask block and their binding to the top level.
module brm_checker
    import brm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_stall,
    input logic              mask_valid,
    input logic              mask_stall,
    input logic [MASK_W-1:0] mask_value
);

    // A held result stays in place until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mask_valid && mask_stall |=> mask_valid && $stable(mask_value))
        else $error("held result changed");

    // The gain never exceeds one.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        mask_valid |-> mask_value <= MASK_W'(65536))
        else $error("mask value above one");

    // Requests are refused only while a finished result is held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> mask_valid && mask_stall)
        else $error("request stalled without a held result");

    // An open output lets the next request in.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !mask_stall |-> !req_stall)
        else $error("request stalled while output is open");

endmodule

bind butterworth_radial_mask_top brm_checker u_brm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_stall  (req_stall),
    .mask_valid (mask_valid),
    .mask_stall (mask_stall),
    .mask_value (mask_value)
);
